/* rtl/pcaf_pkg.sv */
// pcaf_pkg: shared types, constants and codes of the per-class admission block
// no dependencies
`timescale 1ns / 1ps

package pcaf_pkg;

  // default sizes of the wait queue and the job tag
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TAG_WIDTH_DEF   = 8;

  // fixed field widths
  localparam int NUM_CLASSES = 4;
  localparam int CLS_W       = 2;
  localparam int CNT_W       = 4;
  localparam int TOT_W       = 5;
  localparam int KIND_W      = 3;

  // one release delivers at most this many results
  localparam int MAX_RESULTS = 17;
  localparam int MAX_STARTS  = MAX_RESULTS - 1;

  // configuration port
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  // input mode codes
  localparam logic MODE_REQUEST = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  // result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_STARTED  = 3'd0,
    KIND_QUEUED   = 3'd1,
    KIND_REFUSED  = 3'd2,
    KIND_RELEASED = 3'd3,
    KIND_IGNORED  = 3'd4
  } kind_t;

  // register indexes, taken from paddr[4:2]
  typedef enum logic [2:0] {
    REG_LIMIT_CLASS0 = 3'd0,
    REG_LIMIT_CLASS1 = 3'd1,
    REG_LIMIT_CLASS2 = 3'd2,
    REG_LIMIT_CLASS3 = 3'd3,
    REG_LIMIT_TOTAL  = 3'd4
  } reg_idx_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_CHK
  } state_t;

  // limits handed from the register block to the controller
  typedef struct packed {
    logic [NUM_CLASSES-1:0][CNT_W-1:0] cls;
    logic [TOT_W-1:0]                  total;
  } limits_t;

  // reset values of the limits (class 3 in the top slot)
  localparam logic [NUM_CLASSES-1:0][CNT_W-1:0] LIM_CLASS_RST = {4'd1, 4'd2, 4'd6, 4'd4};
  localparam logic [TOT_W-1:0]                  LIM_TOTAL_RST = 5'd8;

endpackage

/* rtl/per_class_admission_with_fifo.sv */
// per_class_admission_with_fifo: top level of the per-class admission controller
// depends on pcaf_pkg, pcaf_regs, pcaf_ctrl, pcaf_ram
//
//  channel | direction | fields
//  in_     | slave     | tuser: mode; tdata: job_class, job_tag
//  out_    | master    | tuser: kind; tdata: out_tag, out_class; tlast: last
//  cfg_    | APB slave | limit_class0..3 at 0x00..0x0c, limit_total at 0x10
//
// A request is decided when accepted. A release of a running class enters
// ST_RD; each started entry passes ST_CHK and ST_RD again, and the pump ends
// in ST_CHK at a misfit head; a start is a queue RAM read and a fit check.
// Reset is synchronous and clears the counters and queue pointers; the queue
// RAM needs no clearing. One output register holds results; the input waits
// during a pump and while that register is full and not taken.
`timescale 1ns / 1ps

module per_class_admission_with_fifo import pcaf_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int TAG_WIDTH   = TAG_WIDTH_DEF,
  localparam int IN_TDW  = ((CLS_W + TAG_WIDTH + 7) / 8) * 8,
  localparam int OUT_TDW = ((TAG_WIDTH + CLS_W + 7) / 8) * 8
) (
  input  logic               clk,
  input  logic               rst_n,
  // input items
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [IN_TDW-1:0]  in_tdata,   // job_class, job_tag, zero fill
  input  logic               in_tuser,   // mode
  // results
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [OUT_TDW-1:0] out_tdata,  // out_tag, out_class, zero fill
  output logic [KIND_W-1:0]  out_tuser,  // kind
  output logic               out_tlast,
  // configuration
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [CFG_AW-1:0]  cfg_paddr,
  input  logic [CFG_DW-1:0]  cfg_pwdata,
  output logic [CFG_DW-1:0]  cfg_prdata,
  output logic               cfg_pready
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int ENT_W = CLS_W + TAG_WIDTH;

  limits_t              limits;
  kind_t                res_kind;
  logic [TAG_WIDTH-1:0] res_tag;
  logic [CLS_W-1:0]     res_cls;
  logic                 ram_we;
  logic [PTR_W-1:0]     ram_waddr;
  logic [PTR_W-1:0]     ram_raddr;
  logic [ENT_W-1:0]     ram_wdata;
  logic [ENT_W-1:0]     ram_rdata;

  // limit registers
  pcaf_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .limits  (limits)
  );

  // admission sequencer
  pcaf_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_WIDTH   (TAG_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .limits    (limits),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_mode   (in_tuser),
    .in_class  (in_tdata[CLS_W-1:0]),
    .in_tag    (in_tdata[CLS_W +: TAG_WIDTH]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (res_kind),
    .out_tag   (res_tag),
    .out_class (res_cls),
    .out_last  (out_tlast),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // wait queue storage
  pcaf_ram #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // result packing
  assign out_tuser = res_kind;
  assign out_tdata = OUT_TDW'({res_cls, res_tag});

endmodule

/* rtl/pcaf_ram.sv */
// pcaf_ram: generic single-write, single-read RAM with registered read data
// no dependencies
`timescale 1ns / 1ps

module pcaf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/pcaf_regs.sv */
// pcaf_regs: APB-style limit registers of the admission block
// depends on pcaf_pkg
`timescale 1ns / 1ps

module pcaf_regs import pcaf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output limits_t           limits
);

  limits_t  limits_r;
  limits_t  limits_nxt;
  logic     wr_en;
  reg_idx_t reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = reg_idx_t'(paddr[4:2]);
  assign limits  = limits_r;

  // register write decode
  always_comb begin
    limits_nxt = limits_r;
    if (wr_en) begin
      unique case (reg_sel)
        REG_LIMIT_CLASS0: limits_nxt.cls[0] = pwdata[CNT_W-1:0];
        REG_LIMIT_CLASS1: limits_nxt.cls[1] = pwdata[CNT_W-1:0];
        REG_LIMIT_CLASS2: limits_nxt.cls[2] = pwdata[CNT_W-1:0];
        REG_LIMIT_CLASS3: limits_nxt.cls[3] = pwdata[CNT_W-1:0];
        REG_LIMIT_TOTAL:  limits_nxt.total  = pwdata[TOT_W-1:0];
        default:          limits_nxt        = limits_r;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (reg_sel)
      REG_LIMIT_CLASS0: prdata = CFG_DW'(limits_r.cls[0]);
      REG_LIMIT_CLASS1: prdata = CFG_DW'(limits_r.cls[1]);
      REG_LIMIT_CLASS2: prdata = CFG_DW'(limits_r.cls[2]);
      REG_LIMIT_CLASS3: prdata = CFG_DW'(limits_r.cls[3]);
      REG_LIMIT_TOTAL:  prdata = CFG_DW'(limits_r.total);
      default:          prdata = '0;
    endcase
  end

  // limit registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limits_r.cls   <= LIM_CLASS_RST;
      limits_r.total <= LIM_TOTAL_RST;
    end else begin
      limits_r <= limits_nxt;
    end
  end

endmodule

/* rtl/pcaf_ctrl.sv */
// pcaf_ctrl: admission sequencer, in-flight counters, queue pointers, output register
// depends on pcaf_pkg; drives the wait-queue RAM ports
`timescale 1ns / 1ps

module pcaf_ctrl import pcaf_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int TAG_WIDTH   = TAG_WIDTH_DEF,
  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int ENT_W = CLS_W + TAG_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  limits_t              limits,
  // input items
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_mode,
  input  logic [CLS_W-1:0]     in_class,
  input  logic [TAG_WIDTH-1:0] in_tag,
  // results
  output logic                 out_valid,
  input  logic                 out_ready,
  output kind_t                out_kind,
  output logic [TAG_WIDTH-1:0] out_tag,
  output logic [CLS_W-1:0]     out_class,
  output logic                 out_last,
  // wait-queue RAM
  output logic                 ram_we,
  output logic [PTR_W-1:0]     ram_waddr,
  output logic [ENT_W-1:0]     ram_wdata,
  output logic [PTR_W-1:0]     ram_raddr,
  input  logic [ENT_W-1:0]     ram_rdata
);

  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int NST_W  = $clog2(MAX_STARTS + 1);

  state_t                            state_r, state_nxt;
  logic [TOT_W-1:0]                  total_r, total_nxt;
  logic [NUM_CLASSES-1:0][CNT_W-1:0] ccnt_r, ccnt_nxt;
  logic [PTR_W-1:0]                  head_r, head_nxt;
  logic [PTR_W-1:0]                  tail_r, tail_nxt;
  logic [QCNT_W-1:0]                 qcnt_r, qcnt_nxt;
  logic [NST_W-1:0]                  nstart_r, nstart_nxt;
  kind_t                             pend_kind_r, pend_kind_nxt;
  logic [TAG_WIDTH-1:0]              pend_tag_r, pend_tag_nxt;
  logic [CLS_W-1:0]                  pend_cls_r, pend_cls_nxt;
  logic                              ov_r, ov_nxt;
  kind_t                             okind_r, okind_nxt;
  logic [TAG_WIDTH-1:0]              otag_r, otag_nxt;
  logic [CLS_W-1:0]                  ocls_r, ocls_nxt;
  logic                              olast_r, olast_nxt;

  logic                 load_ok;
  logic                 accept;
  logic                 fit_in;
  logic                 fit_hd;
  logic                 q_full;
  logic                 pump_done;
  logic [CLS_W-1:0]     hd_cls;
  logic [TAG_WIDTH-1:0] hd_tag;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // handshake and admission checks
  assign load_ok   = !ov_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && load_ok;
  assign accept    = in_valid && in_ready;
  assign hd_cls    = ram_rdata[CLS_W-1:0];
  assign hd_tag    = ram_rdata[ENT_W-1:CLS_W];
  assign fit_in    = (total_r < limits.total) && (ccnt_r[in_class] < limits.cls[in_class]);
  assign fit_hd    = (total_r < limits.total) && (ccnt_r[hd_cls] < limits.cls[hd_cls]);
  assign q_full    = (qcnt_r >= QCNT_W'(QUEUE_DEPTH));
  assign pump_done = (qcnt_r == '0) || (nstart_r == NST_W'(MAX_STARTS));

  // queue RAM: head is read every cycle, writes only at the tail
  assign ram_raddr = head_r;
  assign ram_waddr = tail_r;
  assign ram_wdata = {in_tag, in_class};

  assign out_valid = ov_r;
  assign out_kind  = okind_r;
  assign out_tag   = otag_r;
  assign out_class = ocls_r;
  assign out_last  = olast_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_mode == MODE_RELEASE && ccnt_r[in_class] != '0) begin
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        if (!pump_done) begin
          state_nxt = ST_CHK;
        end else if (load_ok) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_CHK: begin
        if (load_ok) begin
          state_nxt = fit_hd ? ST_RD : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // counters, queue pointers and result datapath
  always_comb begin
    total_nxt     = total_r;
    ccnt_nxt      = ccnt_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    qcnt_nxt      = qcnt_r;
    nstart_nxt    = nstart_r;
    pend_kind_nxt = pend_kind_r;
    pend_tag_nxt  = pend_tag_r;
    pend_cls_nxt  = pend_cls_r;
    ov_nxt        = ov_r && !out_ready;
    okind_nxt     = okind_r;
    otag_nxt      = otag_r;
    ocls_nxt      = ocls_r;
    olast_nxt     = olast_r;
    ram_we        = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          otag_nxt  = in_tag;
          ocls_nxt  = in_class;
          olast_nxt = 1'b1;
          if (in_mode == MODE_REQUEST) begin
            ov_nxt = 1'b1;
            if (fit_in) begin
              total_nxt          = total_r + 1'b1;
              ccnt_nxt[in_class] = ccnt_r[in_class] + 1'b1;
              okind_nxt          = KIND_STARTED;
            end else if (q_full) begin
              okind_nxt = KIND_REFUSED;
            end else begin
              ram_we    = 1'b1;
              tail_nxt  = ptr_inc(tail_r);
              qcnt_nxt  = qcnt_r + 1'b1;
              okind_nxt = KIND_QUEUED;
            end
          end else if (ccnt_r[in_class] == '0) begin
            ov_nxt    = 1'b1;
            okind_nxt = KIND_IGNORED;
          end else begin
            // release result is held until we know whether a start follows
            ccnt_nxt[in_class] = ccnt_r[in_class] - 1'b1;
            if (total_r != '0) begin
              total_nxt = total_r - 1'b1;
            end
            pend_kind_nxt = KIND_RELEASED;
            pend_tag_nxt  = in_tag;
            pend_cls_nxt  = in_class;
            nstart_nxt    = '0;
          end
        end
      end
      ST_RD: begin
        if (pump_done && load_ok) begin
          ov_nxt    = 1'b1;
          okind_nxt = pend_kind_r;
          otag_nxt  = pend_tag_r;
          ocls_nxt  = pend_cls_r;
          olast_nxt = 1'b1;
        end
      end
      ST_CHK: begin
        if (load_ok) begin
          ov_nxt    = 1'b1;
          okind_nxt = pend_kind_r;
          otag_nxt  = pend_tag_r;
          ocls_nxt  = pend_cls_r;
          olast_nxt = !fit_hd;
          if (fit_hd) begin
            // start the head entry
            total_nxt        = total_r + 1'b1;
            ccnt_nxt[hd_cls] = ccnt_r[hd_cls] + 1'b1;
            head_nxt         = ptr_inc(head_r);
            qcnt_nxt         = qcnt_r - 1'b1;
            nstart_nxt       = nstart_r + 1'b1;
            pend_kind_nxt    = KIND_STARTED;
            pend_tag_nxt     = hd_tag;
            pend_cls_nxt     = hd_cls;
          end
        end
      end
      default: ov_nxt = ov_r && !out_ready;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      total_r  <= '0;
      ccnt_r   <= '0;
      head_r   <= '0;
      tail_r   <= '0;
      qcnt_r   <= '0;
      nstart_r <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      total_r  <= total_nxt;
      ccnt_r   <= ccnt_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      qcnt_r   <= qcnt_nxt;
      nstart_r <= nstart_nxt;
      ov_r     <= ov_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pend_kind_r <= pend_kind_nxt;
    pend_tag_r  <= pend_tag_nxt;
    pend_cls_r  <= pend_cls_nxt;
    okind_r     <= okind_nxt;
    otag_r      <= otag_nxt;
    ocls_r      <= ocls_nxt;
    olast_r     <= olast_nxt;
  end

`ifndef SYNTHESIS
  a_qcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qcnt_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (qcnt_r == '0) |-> (head_r == tail_r))
    else $error("empty queue with head and tail apart");

  a_start_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHK && load_ok && fit_hd) |-> (qcnt_r != '0))
    else $error("start from an empty queue");

  a_pump_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nstart_r <= NST_W'(MAX_STARTS))
    else $error("too many starts for one release");

  a_accept_effect: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (ov_r || state_r == ST_RD))
    else $error("accepted item left no result and no pump");
`endif

endmodule

/* dv/pcaf_admission_checker.sv */
// pcaf_admission_checker: watches the ports of the per-class admission block, predicts every
// result from its own copy of the counters, limits and wait queue, and compares the results
// depends on pcaf_pkg
`timescale 1ns / 1ps

module pcaf_admission_checker import pcaf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [15:0]       in_tdata,    // job_class, job_tag, zero fill
  input  logic              in_tuser,    // mode
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [15:0]       out_tdata,   // out_tag, out_class, zero fill
  input  logic [KIND_W-1:0] out_tuser,   // kind
  input  logic              out_tlast,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic              cfg_pready,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output int                fail_count,
  output int                results_pending
);

  typedef struct packed {
    kind_t      kind;
    logic [7:0] tag;
    logic [1:0] cls;
    logic       last;
  } job_result_t;

  typedef struct packed {
    logic [1:0] cls;
    logic [7:0] tag;
  } waiting_job_t;

  // shadow of the limits and the admission state
  logic [CNT_W-1:0] class_limit [NUM_CLASSES];
  logic [TOT_W-1:0] total_limit;
  logic [CNT_W-1:0] class_running [NUM_CLASSES];
  logic [TOT_W-1:0] total_running;
  waiting_job_t     waiting_jobs[$];
  job_result_t      awaited_results[$];

  initial fail_count = 0;

  function automatic bit slot_free(logic [1:0] cls);
    return (total_running < total_limit) && (class_running[cls] < class_limit[cls]);
  endfunction

  function automatic void take_slot(logic [1:0] cls);
    total_running      = total_running + 1'b1;
    class_running[cls] = class_running[cls] + 1'b1;
  endfunction

  function automatic void expect_result(kind_t kind, logic [7:0] tag, logic [1:0] cls);
    job_result_t r;
    r.kind = kind;
    r.tag  = tag;
    r.cls  = cls;
    r.last = 1'b0;
    awaited_results.push_back(r);
  endfunction

  // works out every result one input transfer causes
  function automatic void admit_job(logic mode, logic [1:0] cls, logic [7:0] tag);
    waiting_job_t head;
    int           n;
    n = 1;
    if (mode == MODE_REQUEST) begin
      if (slot_free(cls)) begin
        take_slot(cls);
        expect_result(KIND_STARTED, tag, cls);
      end else if (waiting_jobs.size() >= QUEUE_DEPTH_DEF) begin
        expect_result(KIND_REFUSED, tag, cls);
      end else begin
        head.cls = cls;
        head.tag = tag;
        waiting_jobs.push_back(head);
        expect_result(KIND_QUEUED, tag, cls);
      end
    end else if (class_running[cls] == '0) begin
      expect_result(KIND_IGNORED, tag, cls);
    end else begin
      class_running[cls] = class_running[cls] - 1'b1;
      if (total_running != '0) total_running = total_running - 1'b1;
      expect_result(KIND_RELEASED, tag, cls);
      // pump the queue from the head until it empties, one does not fit or n hits MAX_RESULTS
      while (waiting_jobs.size() > 0 && n < MAX_RESULTS) begin
        head = waiting_jobs[0];
        if (!slot_free(head.cls)) break;
        take_slot(head.cls);
        void'(waiting_jobs.pop_front());
        expect_result(KIND_STARTED, head.tag, head.cls);
        n++;
      end
    end
    awaited_results[awaited_results.size()-1].last = 1'b1;
  endfunction

  function automatic void report_error(string what, job_result_t want, job_result_t got);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t %s: expected kind %0d tag %02h class %0d last %0b, got kind %0d tag %02h class %0d last %0b",
               $realtime, what, want.kind, want.tag, want.cls, want.last,
               got.kind, got.tag, got.cls, got.last);
  endfunction

  // sample every transfer at the rising edge
  always @(posedge clk) begin
    job_result_t got;
    job_result_t want;
    if (!rst_n) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        class_limit[c]   = LIM_CLASS_RST[c];
        class_running[c] = '0;
      end
      total_limit   = LIM_TOTAL_RST;
      total_running = '0;
      waiting_jobs.delete();
      awaited_results.delete();
    end else begin
      // register writes
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (reg_idx_t'(cfg_paddr[4:2]))
          REG_LIMIT_CLASS0: class_limit[0] = cfg_pwdata[CNT_W-1:0];
          REG_LIMIT_CLASS1: class_limit[1] = cfg_pwdata[CNT_W-1:0];
          REG_LIMIT_CLASS2: class_limit[2] = cfg_pwdata[CNT_W-1:0];
          REG_LIMIT_CLASS3: class_limit[3] = cfg_pwdata[CNT_W-1:0];
          REG_LIMIT_TOTAL:  total_limit    = cfg_pwdata[TOT_W-1:0];
          default: ;
        endcase
      end
      // result transfer, checked before this edge's input is predicted
      if (out_tvalid && out_tready) begin
        got.kind = kind_t'(out_tuser);
        got.tag  = out_tdata[7:0];
        got.cls  = out_tdata[9:8];
        got.last = out_tlast;
        if (awaited_results.size() == 0) begin
          want = '0;
          report_error("result with none expected", want, got);
        end else begin
          want = awaited_results.pop_front();
          if (got.kind !== want.kind || got.tag !== want.tag || got.cls !== want.cls ||
              got.last !== want.last)
            report_error("result mismatch", want, got);
        end
      end
      // input transfer
      if (in_tvalid && in_tready)
        admit_job(in_tuser, in_tdata[1:0], in_tdata[9:2]);
    end
    results_pending = awaited_results.size();
  end

endmodule

/* dv/per_class_admission_with_fifo_test.sv */
// per_class_admission_with_fifo_test: drives requests, releases and limit writes into the
// per-class admission block, with random idling on both channels, and gives the verdict
// depends on pcaf_pkg, per_class_admission_with_fifo, pcaf_admission_checker
`timescale 1ns / 1ps

module per_class_admission_with_fifo_test;
  import pcaf_pkg::*;

  localparam int CYCLE_LIMIT    = 1000000;
  localparam int SETTLE_CYCLES  = 50;
  localparam int HOLD_CYCLES    = 300;
  localparam int NUM_PHASES     = 6;
  localparam int ITEMS_PER_PHASE = 70;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [15:0]       in_tdata;    // job_class, job_tag, zero fill
  logic              in_tuser;    // mode
  logic              out_tvalid;
  logic              out_tready;
  logic [15:0]       out_tdata;   // out_tag, out_class, zero fill
  logic [KIND_W-1:0] out_tuser;   // kind
  logic              out_tlast;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  int fail_count;
  int results_pending;
  int cycle_count;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_kicks;
  int hold_seen;
  int hold_left;
  int jobs_issued [NUM_CLASSES];

  per_class_admission_with_fifo dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_prdata, .cfg_pready
  );

  pcaf_admission_checker checker_i (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_pready, .cfg_paddr, .cfg_pwdata,
    .fail_count, .results_pending
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver: random stalls plus an occasional long hold-off
  initial begin
    hold_seen = 0;
    hold_left = 0;
  end
  always @(negedge clk) begin
    if (hold_kicks != hold_seen) begin
      hold_seen = hold_kicks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // one input transfer, with random gaps before it
  task automatic send_job(logic mode, logic [1:0] cls, logic [7:0] tag);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {6'b0, tag, cls};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_limit(reg_idx_t idx, int value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic write_all_limits(int c0, int c1, int c2, int c3, int total);
    write_limit(REG_LIMIT_CLASS0, c0);
    write_limit(REG_LIMIT_CLASS1, c1);
    write_limit(REG_LIMIT_CLASS2, c2);
    write_limit(REG_LIMIT_CLASS3, c3);
    write_limit(REG_LIMIT_TOTAL, total);
  endtask

  // stop offering, then wait until every result is in and the block has settled
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // random request or release; releases mostly name a class that has jobs out
  task automatic send_random_job(int request_pct);
    logic [1:0] cls;
    int         outstanding;
    cls = 2'($urandom_range(3));
    outstanding = jobs_issued[0] + jobs_issued[1] + jobs_issued[2] + jobs_issued[3];
    if ($urandom_range(99) < request_pct) begin
      jobs_issued[cls]++;
      send_job(MODE_REQUEST, cls, 8'($urandom_range(255)));
    end else begin
      if (outstanding > 0 && $urandom_range(99) < 85) begin
        while (jobs_issued[cls] == 0) cls = 2'($urandom_range(3));
        jobs_issued[cls]--;
      end
      send_job(MODE_RELEASE, cls, 8'($urandom_range(255)));
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = 1'b0;
    out_tready  = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    hold_kicks  = 0;
    send_idle_pct = 11;
    recv_idle_pct = 59;
    for (int c = 0; c < NUM_CLASSES; c++) jobs_issued[c] = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed part at reset limits
    send_job(MODE_RELEASE, 2'd0, 8'h00);  // release with nothing running
    send_job(MODE_REQUEST, 2'd3, 8'h00);
    send_job(MODE_REQUEST, 2'd3, 8'hff);  // class full, waits
    send_job(MODE_REQUEST, 2'd2, 8'h12);
    send_job(MODE_REQUEST, 2'd2, 8'h34);
    send_job(MODE_REQUEST, 2'd2, 8'h56);  // waits behind class 3
    send_job(MODE_REQUEST, 2'd0, 8'h78);  // overtakes the waiting ones
    send_job(MODE_RELEASE, 2'd3, 8'h00);  // pump stops at the class 2 head
    send_job(MODE_RELEASE, 2'd2, 8'h12);
    drain_results();

    // total limit at the running count: fill the queue, then one refusal
    write_all_limits(15, 15, 15, 15, 4);
    for (int i = 0; i <= QUEUE_DEPTH_DEF; i++)
      send_job(MODE_REQUEST, 2'(i % NUM_CLASSES), 8'(8'h80 + i));
    drain_results();

    // raising the limit alone starts nothing; one release pumps the whole queue
    write_limit(REG_LIMIT_TOTAL, 31);
    send_job(MODE_RELEASE, 2'd0, 8'h78);
    drain_results();

    // random phases
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: write_all_limits($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(1, 6),
                            $urandom_range(1, 6), $urandom_range(4, 12));
        1: write_all_limits(15, 15, 15, 15, 31);
        2: write_all_limits(1, 1, 1, 1, 2);     // below what is already running
        3: write_all_limits(0, 0, 0, 0, 0);
        4: write_all_limits($urandom_range(15), $urandom_range(15), $urandom_range(15),
                            $urandom_range(15), $urandom_range(31));
        default: write_all_limits(4, 6, 2, 1, 8);
      endcase
      if (p < 2) begin
        send_idle_pct = 11;
        recv_idle_pct = 59;
      end else if (p < 4) begin
        send_idle_pct = 59;
        recv_idle_pct = 11;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (p == 4 && i == 20) hold_kicks++;
        send_random_job((p == 1 || p == 4) ? 70 : 55);
      end
      drain_results();
    end

    if (fail_count == 0 && results_pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* per_class_admission_with_fifo.f */
rtl/pcaf_pkg.sv
rtl/pcaf_ram.sv
rtl/pcaf_regs.sv
rtl/pcaf_ctrl.sv
rtl/per_class_admission_with_fifo.sv
dv/pcaf_admission_checker.sv
dv/per_class_admission_with_fifo_test.sv
